// File: rtl/core/dcasl_pkg.sv
// ----------------------------------------------------------------------------
// dcasl_pkg
// Shared types, constants and helpers for the dual channel ADC low-pass block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcasl_pkg;

  // sample and accumulator widths
  localparam int unsigned SAMPLE_BITS     = 10;
  localparam int unsigned ACC_BITS        = 32;
  localparam int unsigned CUR_PRESHIFT    = 3;

  // configuration register widths
  localparam int unsigned SHIFT_BITS      = 4;
  localparam int unsigned CUR_START_BITS  = 14;
  localparam int unsigned CTL_START_BITS  = 12;
  localparam int unsigned OFFSET_BITS     = 14;
  localparam int unsigned CFG_INDEX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS   = 14;

  // result field widths
  localparam int unsigned CUR_VALUE_BITS  = 16;
  localparam int unsigned CTL_VALUE_BITS  = 13;
  localparam int unsigned SUM_BITS        = CUR_VALUE_BITS;

  // configuration reset values
  localparam logic [SHIFT_BITS-1:0]     CUR_SHIFT_RST  = SHIFT_BITS'(6);
  localparam logic [SHIFT_BITS-1:0]     CTL_SHIFT_RST  = SHIFT_BITS'(4);
  localparam logic [CUR_START_BITS-1:0] CUR_START_RST  = CUR_START_BITS'(8110);
  localparam logic [CTL_START_BITS-1:0] CTL_START_RST  = CTL_START_BITS'(1730);
  localparam logic [OFFSET_BITS-1:0]    CUR_OFFSET_RST = OFFSET_BITS'(8110);

  typedef logic [ACC_BITS-1:0] acc_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CUR_SHIFT  = 3'd0,
    CFG_CTL_SHIFT  = 3'd1,
    CFG_CUR_START  = 3'd2,
    CFG_CTL_START  = 3'd3,
    CFG_CUR_OFFSET = 3'd4
  } cfg_index_e;

  // one half-buffer of conversions
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] control_first;
    logic [SAMPLE_BITS-1:0] current_first;
    logic [SAMPLE_BITS-1:0] control_second;
    logic [SAMPLE_BITS-1:0] current_second;
  } in_item_t;

  // filtered result
  typedef struct packed {
    logic signed [CUR_VALUE_BITS-1:0] current_value;
    logic [CTL_VALUE_BITS-1:0]        control_value;
  } out_item_t;

  // accumulator preload: start * 2^(k+1) - start, modulo accumulator width
  function automatic acc_t preload(acc_t start, logic [SHIFT_BITS-1:0] k);
    logic [SHIFT_BITS:0] kp1;
    kp1 = {1'b0, k} + 1'b1;
    return (start << kp1) - start;
  endfunction

  localparam acc_t CUR_ACC_RST = preload(acc_t'(CUR_START_RST), CUR_SHIFT_RST);
  localparam acc_t CTL_ACC_RST = preload(acc_t'(CTL_START_RST), CTL_SHIFT_RST);

endpackage

`default_nettype wire

// File: rtl/core/dcasl_lpf.sv
// ----------------------------------------------------------------------------
// dcasl_lpf
// Two chained steps of a shift-based first-order low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

module dcasl_lpf (
  input  wire dcasl_pkg::acc_t                     acc_i,
  input  wire logic [dcasl_pkg::SHIFT_BITS-1:0]    shift_i,
  input  wire dcasl_pkg::acc_t                     x_first_i,
  input  wire dcasl_pkg::acc_t                     x_second_i,
  output dcasl_pkg::acc_t                          acc_o,
  output logic [dcasl_pkg::SUM_BITS-1:0]           out_sum_o
);

  logic [dcasl_pkg::SHIFT_BITS:0]          shift_p1;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   y_first;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   y_second;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   y_first_k;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   y_second_k;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   out_first;
  logic signed [dcasl_pkg::ACC_BITS-1:0]   out_second;
  dcasl_pkg::acc_t                         acc_mid;

  assign shift_p1 = {1'b0, shift_i} + 1'b1;

  // first round: y = x + acc, acc = x + y - (y >> k)
  always_comb begin
    y_first   = x_first_i + acc_i;
    y_first_k = y_first >>> shift_i;
    out_first = y_first >>> shift_p1;
    acc_mid   = x_first_i + dcasl_pkg::acc_t'(y_first) - dcasl_pkg::acc_t'(y_first_k);
  end

  // second round runs on the updated accumulator
  always_comb begin
    y_second   = x_second_i + acc_mid;
    y_second_k = y_second >>> shift_i;
    out_second = y_second >>> shift_p1;
    acc_o      = x_second_i + dcasl_pkg::acc_t'(y_second) - dcasl_pkg::acc_t'(y_second_k);
  end

  // low bits of the two filter outputs are all the result needs
  assign out_sum_o = out_first[dcasl_pkg::SUM_BITS-1:0] + out_second[dcasl_pkg::SUM_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/dual_channel_adc_shift_lowpass_top.sv
// ----------------------------------------------------------------------------
// dual_channel_adc_shift_lowpass_top
// Low-pass filters the control pin and motor current conversions of one
// half-buffer and returns the summed filter outputs, current offset-corrected.
// A request waits in the input register, its result in the result register.
// Throughput: one request per cycle while not stalled; both filter rounds of
// each channel are chained in the single compute stage between the registers.
// Reset: configuration returns to its defaults, both accumulators are preloaded
// from the default start and shift values, and both stages come up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_channel_adc_shift_lowpass_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // input channel
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire dcasl_pkg::in_item_t                     in_data_i,
  // output channel
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output dcasl_pkg::out_item_t                         out_data_o,
  // configuration write channel
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [dcasl_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire logic [dcasl_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  logic                                     cfg_we;
  logic                                     cur_load;
  logic                                     ctl_load;
  logic [dcasl_pkg::SHIFT_BITS-1:0]         cur_shift_q, cur_shift_d;
  logic [dcasl_pkg::SHIFT_BITS-1:0]         ctl_shift_q, ctl_shift_d;
  logic [dcasl_pkg::CUR_START_BITS-1:0]     cur_start_q, cur_start_d;
  logic [dcasl_pkg::CTL_START_BITS-1:0]     ctl_start_q, ctl_start_d;
  logic [dcasl_pkg::OFFSET_BITS-1:0]        cur_offset_q, cur_offset_d;
  dcasl_pkg::acc_t                          cur_acc_q, cur_acc_d;
  dcasl_pkg::acc_t                          ctl_acc_q, ctl_acc_d;
  dcasl_pkg::acc_t                          cur_acc_new;
  dcasl_pkg::acc_t                          ctl_acc_new;
  logic [dcasl_pkg::SUM_BITS-1:0]           cur_sum;
  logic [dcasl_pkg::SUM_BITS-1:0]           ctl_sum;
  logic                                     in_acc;
  logic                                     s1_adv;
  logic                                     s1_valid_q, s1_valid_d;
  logic                                     out_valid_q, out_valid_d;
  dcasl_pkg::in_item_t                      s1_data_q;
  dcasl_pkg::out_item_t                     out_data_q, out_data_d;
  dcasl_pkg::acc_t                          cur_x_first;
  dcasl_pkg::acc_t                          cur_x_second;
  dcasl_pkg::acc_t                          ctl_x_first;
  dcasl_pkg::acc_t                          ctl_x_second;

  // configuration decode
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cur_shift_d  = cur_shift_q;
    ctl_shift_d  = ctl_shift_q;
    cur_start_d  = cur_start_q;
    ctl_start_d  = ctl_start_q;
    cur_offset_d = cur_offset_q;
    cur_load     = 1'b0;
    ctl_load     = 1'b0;
    if (cfg_we) begin
      case (cfg_index_i)
        dcasl_pkg::CFG_CUR_SHIFT: begin
          cur_shift_d = cfg_data_i[dcasl_pkg::SHIFT_BITS-1:0];
          cur_load    = 1'b1;
        end
        dcasl_pkg::CFG_CTL_SHIFT: begin
          ctl_shift_d = cfg_data_i[dcasl_pkg::SHIFT_BITS-1:0];
          ctl_load    = 1'b1;
        end
        dcasl_pkg::CFG_CUR_START: begin
          cur_start_d = cfg_data_i[dcasl_pkg::CUR_START_BITS-1:0];
          cur_load    = 1'b1;
        end
        dcasl_pkg::CFG_CTL_START: begin
          ctl_start_d = cfg_data_i[dcasl_pkg::CTL_START_BITS-1:0];
          ctl_load    = 1'b1;
        end
        dcasl_pkg::CFG_CUR_OFFSET: begin
          cur_offset_d = cfg_data_i[dcasl_pkg::OFFSET_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake: the input register drains into the result register
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // sample conditioning: current samples get the fixed pre-shift
  assign cur_x_first  = dcasl_pkg::acc_t'({s1_data_q.current_first,
                                           dcasl_pkg::CUR_PRESHIFT'(0)});
  assign cur_x_second = dcasl_pkg::acc_t'({s1_data_q.current_second,
                                           dcasl_pkg::CUR_PRESHIFT'(0)});
  assign ctl_x_first  = dcasl_pkg::acc_t'(s1_data_q.control_first);
  assign ctl_x_second = dcasl_pkg::acc_t'(s1_data_q.control_second);

  dcasl_lpf u_cur_lpf (
    .acc_i      (cur_acc_q),
    .shift_i    (cur_shift_q),
    .x_first_i  (cur_x_first),
    .x_second_i (cur_x_second),
    .acc_o      (cur_acc_new),
    .out_sum_o  (cur_sum)
  );

  dcasl_lpf u_ctl_lpf (
    .acc_i      (ctl_acc_q),
    .shift_i    (ctl_shift_q),
    .x_first_i  (ctl_x_first),
    .x_second_i (ctl_x_second),
    .acc_o      (ctl_acc_new),
    .out_sum_o  (ctl_sum)
  );

  // result fields
  always_comb begin
    out_data_d.current_value = $signed(cur_sum - dcasl_pkg::SUM_BITS'(cur_offset_q));
    out_data_d.control_value = ctl_sum[dcasl_pkg::CTL_VALUE_BITS-1:0];
  end

  // accumulator next state: preload on config, filter update on advance
  always_comb begin
    cur_acc_d = cur_acc_q;
    ctl_acc_d = ctl_acc_q;
    if (cur_load) begin
      cur_acc_d = dcasl_pkg::preload(dcasl_pkg::acc_t'(cur_start_d), cur_shift_d);
    end else if (s1_adv) begin
      cur_acc_d = cur_acc_new;
    end
    if (ctl_load) begin
      ctl_acc_d = dcasl_pkg::preload(dcasl_pkg::acc_t'(ctl_start_d), ctl_shift_d);
    end else if (s1_adv) begin
      ctl_acc_d = ctl_acc_new;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_shift_q  <= dcasl_pkg::CUR_SHIFT_RST;
      ctl_shift_q  <= dcasl_pkg::CTL_SHIFT_RST;
      cur_start_q  <= dcasl_pkg::CUR_START_RST;
      ctl_start_q  <= dcasl_pkg::CTL_START_RST;
      cur_offset_q <= dcasl_pkg::CUR_OFFSET_RST;
      cur_acc_q    <= dcasl_pkg::CUR_ACC_RST;
      ctl_acc_q    <= dcasl_pkg::CTL_ACC_RST;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_shift_q  <= cur_shift_d;
      ctl_shift_q  <= ctl_shift_d;
      cur_start_q  <= cur_start_d;
      ctl_start_q  <= ctl_start_d;
      cur_offset_q <= cur_offset_d;
      cur_acc_q    <= cur_acc_d;
      ctl_acc_q    <= ctl_acc_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  // stall only when both stages are full and the result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // a request leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced request lost");

  // accumulators hold when nothing advances and nothing is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_adv && !cfg_we) |=> ($stable(cur_acc_q) && $stable(ctl_acc_q)))
    else $error("accumulator changed while idle");

  // current shift or start write reloads the current accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_index_i == dcasl_pkg::CFG_CUR_SHIFT ||
                cfg_index_i == dcasl_pkg::CFG_CUR_START))
    |=> (cur_acc_q == dcasl_pkg::preload(dcasl_pkg::acc_t'(cur_start_q), cur_shift_q)))
    else $error("current accumulator not preloaded");

endmodule

`default_nettype wire
